>>> rtl/tree_ancestor_lca_engine_core_assert.svh
`ifndef TREE_ANCESTOR_LCA_ENGINE_CORE_ASSERT_SVH
`define TREE_ANCESTOR_LCA_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tla_pkg.sv
package tla_pkg;

  // Fixed field widths
  localparam int NODE_W = 10;
  localparam int ACT_W  = 2;

  // Default sizing
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

  // Request codes
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_LCA  = 2'd1,
    ACT_KTH  = 2'd2
  } action_e;

  // One ancestor table entry; invalid means above the root
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } anc_entry_t;

  // Write strobes from the sequencer to the store
  typedef struct packed {
    logic anc_we;
    logic dep_we;
  } mem_wr_t;

  // One result item
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic              status;
  } result_t;

endpackage

>>> rtl/tla_store.sv
module tla_store #(
  parameter int MAX_NODES = tla_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = tla_pkg::LEVELS_DEF,
  localparam int AW       = $clog2(MAX_NODES),
  localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1,
  localparam int ANC_AW   = AW + LW
) (
  input  logic                        clk_i,
  input  tla_pkg::mem_wr_t            wr_i,
  input  logic [ANC_AW-1:0]           anc_waddr_i,
  input  tla_pkg::anc_entry_t         anc_wdata_i,
  input  logic [ANC_AW-1:0]           anc_raddr_a_i,
  input  logic [ANC_AW-1:0]           anc_raddr_b_i,
  output tla_pkg::anc_entry_t         anc_rdata_a_o,
  output tla_pkg::anc_entry_t         anc_rdata_b_o,
  input  logic [AW-1:0]               dep_waddr_i,
  input  logic [tla_pkg::NODE_W-1:0]  dep_wdata_i,
  input  logic [AW-1:0]               dep_raddr_i,
  output logic [tla_pkg::NODE_W-1:0]  dep_rdata_o
);

  localparam int ANC_DEPTH = MAX_NODES << LW;

  // Ancestor rows: node index in the upper bits, level in the lower bits
  tla_pkg::anc_entry_t        anc_mem_q [ANC_DEPTH];
  logic [tla_pkg::NODE_W-1:0] dep_mem_q [MAX_NODES];

  tla_pkg::anc_entry_t        anc_rd_a_q;
  tla_pkg::anc_entry_t        anc_rd_b_q;
  logic [tla_pkg::NODE_W-1:0] dep_rd_q;

  // Write ancestor table, read two ports with registered data
  always_ff @(posedge clk_i) begin
    if (wr_i.anc_we) begin
      anc_mem_q[anc_waddr_i] <= anc_wdata_i;
    end
    anc_rd_a_q <= anc_mem_q[anc_raddr_a_i];
    anc_rd_b_q <= anc_mem_q[anc_raddr_b_i];
  end

  // Write depth store, read one port with registered data
  always_ff @(posedge clk_i) begin
    if (wr_i.dep_we) begin
      dep_mem_q[dep_waddr_i] <= dep_wdata_i;
    end
    dep_rd_q <= dep_mem_q[dep_raddr_i];
  end

  assign anc_rdata_a_o = anc_rd_a_q;
  assign anc_rdata_b_o = anc_rd_b_q;
  assign dep_rdata_o   = dep_rd_q;

endmodule

>>> rtl/tla_seq.sv
`include "tree_ancestor_lca_engine_core_assert.svh"

module tla_seq #(
  parameter int MAX_NODES = tla_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = tla_pkg::LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tla_pkg::ACT_W-1:0]   action_i,
  input  logic [tla_pkg::NODE_W-1:0]  node_i,
  input  logic [tla_pkg::NODE_W-1:0]  other_node_i,
  input  logic [tla_pkg::NODE_W-1:0]  steps_i,
  input  logic                        slot_free_i,
  output logic                        done_o,
  output tla_pkg::result_t            result_o
);

  localparam int NW     = tla_pkg::NODE_W;
  localparam int AW     = $clog2(MAX_NODES);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_AW = AW + LW;
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_LD_DEP = 12'b0000_0000_0010,
    ST_LD_SEL = 12'b0000_0000_0100,
    ST_LD_USE = 12'b0000_0000_1000,
    ST_RD_DA  = 12'b0000_0001_0000,
    ST_RD_DB  = 12'b0000_0010_0000,
    ST_CL_SEL = 12'b0000_0100_0000,
    ST_CL_USE = 12'b0000_1000_0000,
    ST_LF_SEL = 12'b0001_0000_0000,
    ST_LF_USE = 12'b0010_0000_0000,
    ST_FN_USE = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [tla_pkg::ACT_W-1:0] act_q, act_d;
  logic [NW-1:0]            node_q, node_d;
  logic [NW-1:0]            oth_q, oth_d;
  logic [NW-1:0]            cur_q, cur_d;
  logic                     curv_q, curv_d;
  logic [NW-1:0]            dist_q, dist_d;
  logic [LW-1:0]            lvl_q, lvl_d;
  tla_pkg::result_t         res_q, res_d;

  // Store access
  tla_pkg::mem_wr_t         wr;
  logic [NW-1:0]            ra_node, rb_node, w_node, dr_node, dw_node;
  logic [LW-1:0]            ra_lvl, rb_lvl, w_lvl;
  tla_pkg::anc_entry_t      wdata, rd_a, rd_b;
  logic [NW-1:0]            dep_wdata, dep_rdata;

  // Shared compare and step unit
  logic                     load_ok, n_ok, m_ok;
  logic                     dist_hit, jump;
  logic [NW-1:0]            span, a_nx;

  assign load_ok = (32'(node_i) == 32'(count_q)) && (32'(count_q) < 32'(MAX_NODES)) &&
                   ((node_i == '0) || (other_node_i < node_i));
  assign n_ok    = 32'(node_i) < 32'(count_q);
  assign m_ok    = 32'(other_node_i) < 32'(count_q);

  assign dist_hit = (dist_q >> lvl_q) != '0;
  assign span     = NW'(1) << lvl_q;
  assign jump     = rd_a.valid && rd_b.valid && (rd_a.node != rd_b.node);
  assign a_nx     = jump ? rd_a.node : cur_q;

  // Sequence loads and queries
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    act_d     = act_q;
    node_d    = node_q;
    oth_d     = oth_q;
    cur_d     = cur_q;
    curv_d    = curv_q;
    dist_d    = dist_q;
    lvl_d     = lvl_q;
    res_d     = res_q;
    wr        = '0;
    ra_node   = cur_q;
    ra_lvl    = lvl_q;
    rb_node   = oth_q;
    rb_lvl    = lvl_q;
    w_node    = node_q;
    w_lvl     = lvl_q;
    wdata     = '0;
    dr_node   = node_q;
    dw_node   = node_q;
    dep_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d  = action_i;
          node_d = node_i;
          oth_d  = other_node_i;
          dist_d = steps_i;
          res_d  = '{node: '0, found: 1'b0, status: 1'b1};
          state_d = ST_DONE;
          case (action_i)
            tla_pkg::ACT_LOAD: begin
              if (load_ok) begin
                res_d.status = 1'b0;
                count_d      = count_q + CW'(1);
                if (node_i == '0) begin
                  // Root: depth zero, every level above the root
                  wr.dep_we = 1'b1;
                  dw_node   = node_i;
                  curv_d    = 1'b0;
                  lvl_d     = '0;
                  state_d   = ST_LD_SEL;
                end else begin
                  dr_node = other_node_i;
                  state_d = ST_LD_DEP;
                end
              end
            end
            tla_pkg::ACT_LCA: begin
              if (n_ok && m_ok) begin
                dr_node = node_i;
                state_d = ST_RD_DA;
              end
            end
            tla_pkg::ACT_KTH: begin
              if (n_ok) begin
                dr_node = node_i;
                state_d = ST_RD_DA;
              end
            end
            default: ;
          endcase
        end
      end

      // Depth of parent plus one, level 0 is the parent
      ST_LD_DEP: begin
        wr.dep_we = 1'b1;
        dep_wdata = dep_rdata + NW'(1);
        wr.anc_we = 1'b1;
        w_lvl     = '0;
        wdata     = '{valid: 1'b1, node: oth_q};
        cur_d     = oth_q;
        curv_d    = 1'b1;
        if (LVL_TOP == '0) begin
          state_d = ST_DONE;
        end else begin
          lvl_d   = LW'(1);
          state_d = ST_LD_SEL;
        end
      end

      // Fetch the level below from the previous ancestor, or mark invalid
      ST_LD_SEL: begin
        if (curv_q) begin
          ra_lvl  = lvl_q - LW'(1);
          state_d = ST_LD_USE;
        end else begin
          wr.anc_we = 1'b1;
          if (lvl_q == LVL_TOP) begin
            state_d = ST_DONE;
          end else begin
            lvl_d = lvl_q + LW'(1);
          end
        end
      end

      ST_LD_USE: begin
        wr.anc_we = 1'b1;
        wdata     = rd_a;
        cur_d     = rd_a.node;
        curv_d    = rd_a.valid;
        if (lvl_q == LVL_TOP) begin
          state_d = ST_DONE;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = ST_LD_SEL;
        end
      end

      // First depth arrives
      ST_RD_DA: begin
        if (act_q == tla_pkg::ACT_KTH) begin
          if (dist_q > dep_rdata) begin
            res_d   = '{node: '0, found: 1'b0, status: 1'b0};
            state_d = ST_DONE;
          end else begin
            cur_d   = node_q;
            lvl_d   = LVL_TOP;
            state_d = ST_CL_SEL;
          end
        end else begin
          dist_d  = dep_rdata;
          dr_node = oth_q;
          state_d = ST_RD_DB;
        end
      end

      // Deeper node climbs by the depth difference
      ST_RD_DB: begin
        if (dist_q < dep_rdata) begin
          cur_d  = oth_q;
          oth_d  = node_q;
          dist_d = dep_rdata - dist_q;
        end else begin
          cur_d  = node_q;
          dist_d = dist_q - dep_rdata;
        end
        lvl_d   = LVL_TOP;
        state_d = ST_CL_SEL;
      end

      ST_CL_SEL: begin
        if (dist_q == '0) begin
          if ((act_q == tla_pkg::ACT_KTH) || (cur_q == oth_q)) begin
            res_d   = '{node: cur_q, found: 1'b1, status: 1'b0};
            state_d = ST_DONE;
          end else begin
            lvl_d   = LVL_TOP;
            state_d = ST_LF_SEL;
          end
        end else if (dist_hit) begin
          state_d = ST_CL_USE;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end

      // Take the jump, or stop at an invalid entry
      ST_CL_USE: begin
        if (rd_a.valid) begin
          cur_d  = rd_a.node;
          dist_d = dist_q - span;
        end else begin
          dist_d = '0;
        end
        state_d = ST_CL_SEL;
      end

      ST_LF_SEL: begin
        state_d = ST_LF_USE;
      end

      // Lift both while ancestors differ; repeat the top level
      ST_LF_USE: begin
        if (jump) begin
          cur_d = rd_a.node;
          oth_d = rd_b.node;
        end
        if (jump && (lvl_q == LVL_TOP)) begin
          state_d = ST_LF_SEL;
        end else if (lvl_q == '0) begin
          ra_node = a_nx;
          ra_lvl  = '0;
          state_d = ST_FN_USE;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = ST_LF_SEL;
        end
      end

      ST_FN_USE: begin
        res_d   = '{node: (rd_a.valid ? rd_a.node : cur_q), found: 1'b1, status: 1'b0};
        state_d = ST_DONE;
      end

      // Hold until the output register takes the result
      ST_DONE: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    node_q <= node_d;
    oth_q  <= oth_d;
    cur_q  <= cur_d;
    curv_q <= curv_d;
    dist_q <= dist_d;
    lvl_q  <= lvl_d;
    res_q  <= res_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign done_o     = (state_q == ST_DONE);
  assign result_o   = res_q;

  tla_store #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_store (
    .clk_i         (clk_i),
    .wr_i          (wr),
    .anc_waddr_i   ({AW'(w_node), w_lvl}),
    .anc_wdata_i   (wdata),
    .anc_raddr_a_i ({AW'(ra_node), ra_lvl}),
    .anc_raddr_b_i ({AW'(rb_node), rb_lvl}),
    .anc_rdata_a_o (rd_a),
    .anc_rdata_b_o (rd_b),
    .dep_waddr_i   (AW'(dw_node)),
    .dep_wdata_i   (dep_wdata),
    .dep_raddr_i   (AW'(dr_node)),
    .dep_rdata_o   (dep_rdata)
  );

  // Checks
  `TLA_ASSERT_IMP(a_count_max, 1'b1, 32'(count_q) <= 32'(MAX_NODES), "load count overflow")
  `TLA_ASSERT_IMP(a_anc_wr_load, wr.anc_we, (state_q == ST_LD_DEP) || (state_q == ST_LD_SEL) || (state_q == ST_LD_USE), "table write outside load")
  `TLA_ASSERT_IMP(a_reject_clean, (state_q == ST_DONE) && res_q.status, !res_q.found && (res_q.node == '0), "reject carries an answer")
  `TLA_ASSERT_NXT(a_count_hold, state_q != ST_IDLE, $stable(count_q), "load count moved while busy")

endmodule

>>> rtl/tree_ancestor_lca_engine_core.sv
// Channel | Handshake                     | Payload
// in      | in_valid_i / in_ready_o       | action_i, node_i, other_node_i, steps_i
// out     | out_valid_o / out_ready_i     | result_node_o, found_o, status_o
//
// One item at a time; in_ready_o is low from acceptance until the result is handed on,
// and the hand-off waits while the output register still holds an untaken result.
// Load: the depth row and one table row per level are written; a reject goes to hand-off.
// Query: accept, depth reads, a descent that jumps where the distance covers the level's span,
// for LCA a lift from the top level, repeated while the ancestors there differ, then hand-off.
// Reset clears the load count, sequencer state and output valid only; table and depth rows are written by loads.
module tree_ancestor_lca_engine_core #(
  parameter int MAX_NODES = tla_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = tla_pkg::LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tla_pkg::ACT_W-1:0]   action_i,
  input  logic [tla_pkg::NODE_W-1:0]  node_i,
  input  logic [tla_pkg::NODE_W-1:0]  other_node_i,
  input  logic [tla_pkg::NODE_W-1:0]  steps_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tla_pkg::NODE_W-1:0]  result_node_o,
  output logic                        found_o,
  output logic                        status_o
);

  logic             out_valid_q;
  tla_pkg::result_t out_q;
  tla_pkg::result_t seq_res;
  logic             seq_done;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  tla_seq #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .node_i       (node_i),
    .other_node_i (other_node_i),
    .steps_i      (steps_i),
    .slot_free_i  (slot_free),
    .done_o       (seq_done),
    .result_o     (seq_res)
  );

  // Advance the output register on a finished result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until transfer
  always_ff @(posedge clk_i) begin
    if (seq_done && slot_free) begin
      out_q <= seq_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_node_o = out_q.node;
  assign found_o       = out_q.found;
  assign status_o      = out_q.status;

endmodule
